FILE: hw/rtl/mbd_pkg.sv
// Shared types, constants and the 2x2 box average for the mip pyramid core.
// Used by mbd_cell, mbd_out_queue and the top level; depends on nothing.
package mbd_pkg;

   // Field widths
   localparam int PIX_W     = 32;
   localparam int DIM_W     = 9;
   localparam int LEVEL_W   = 4;
   localparam int POS_W     = 7;
   localparam int CSR_IDX_W = 2;

   // Channel layout and rounding of the box average
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = PIX_W / CHAN_W;
   localparam int SUM_W    = CHAN_W + 2;
   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(2);

   // Largest dimension code a register can hold, and the size after reset
   localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
   localparam int DIM_RESET    = 256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = CSR_IDX_W'(1);

   // Word handed from one level cell to the next
   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } mbd_tok_type;

   // Result word as it leaves the core
   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   col;
      logic [POS_W-1:0]   row;
      logic               last;
   } mbd_rsp_type;

   // Per-channel rounded mean of four texels
   function automatic logic [PIX_W-1:0] box4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
      logic [SUM_W-1:0] sum;
      logic [PIX_W-1:0] res;
      res = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum = SUM_W'(a[ch*CHAN_W +: CHAN_W]) + SUM_W'(b[ch*CHAN_W +: CHAN_W]) +
               SUM_W'(c[ch*CHAN_W +: CHAN_W]) + SUM_W'(d[ch*CHAN_W +: CHAN_W]) +
               ROUND_BIAS;
         res[ch*CHAN_W +: CHAN_W] = sum[SUM_W-1:2];
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/mbd_cell.sv
// One level of the pyramid: position counters, even-column line store and
// the 2x2 box average that feeds the next level. Depends on mbd_pkg.
module mbd_cell #(
   parameter int MAX_DIM = 256,
   parameter int LEVEL   = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        clear,
   input  logic [mbd_pkg::DIM_W-1:0]   tex_width,
   input  logic [mbd_pkg::DIM_W-1:0]   tex_height,
   input  logic                        in_valid,
   input  logic [mbd_pkg::PIX_W-1:0]   in_pixel,
   output logic                        fire,
   output mbd_pkg::mbd_tok_type        res
);
   import mbd_pkg::*;

   localparam int DimCap = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
   localparam int CntW   = $clog2(DimCap);
   localparam int Depth  = DimCap >> (LEVEL + 1);
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

   logic [CntW-1:0]  col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] shr_w, shr_h, src_w, src_h, col_lim, row_lim;
   logic [DIM_W-1:0] col_ext, row_ext;
   logic             active, col_both, row_both, col_ok, row_ok;
   logic             take, in_block, is_write, is_hold;
   logic [AddrW-1:0] pair_idx;

   logic [PIX_W-1:0] even_mem [Depth];
   logic [PIX_W-1:0] odd_mem  [Depth];
   logic [PIX_W-1:0] even_rd_ff, odd_rd_ff;
   logic [PIX_W-1:0] held_ff, last_even_ff;
   logic [PIX_W-1:0] op_a0, op_a1, op_c0, box_q;

   mbd_tok_type res_ff;

   // Size of the source level this cell reduces
   assign shr_w  = tex_width >> LEVEL;
   assign shr_h  = tex_height >> LEVEL;
   assign src_w  = (shr_w == '0) ? DIM_W'(1) : shr_w;
   assign src_h  = (shr_h == '0) ? DIM_W'(1) : shr_h;
   assign active = ((tex_width >> (LEVEL + 1)) | (tex_height >> (LEVEL + 1))) != '0;

   // A dimension of one reuses its only row or column; odd leftovers drop
   assign col_both = (src_w == DIM_W'(1));
   assign row_both = (src_h == DIM_W'(1));
   assign col_lim  = {src_w[DIM_W-1:1], 1'b0};
   assign row_lim  = {src_h[DIM_W-1:1], 1'b0};
   assign col_ext  = DIM_W'(col_ff);
   assign row_ext  = DIM_W'(row_ff);
   assign col_ok   = col_both ? (col_ff == '0) : (col_ext < col_lim);
   assign row_ok   = row_both ? (row_ff == '0) : (row_ext < row_lim);

   // Classify the incoming word
   assign take     = in_valid && advance && active;
   assign in_block = take && col_ok && row_ok;
   assign is_write = in_block && !col_both && !col_ff[0];
   assign is_hold  = in_block && !is_write && !row_both && !row_ff[0];
   assign fire     = in_block && !is_write && !is_hold;

   // Advance the stream position, row first
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (clear) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (row_ext + DIM_W'(1) >= src_h) begin
            row_in = '0;
            col_in = (col_ext + DIM_W'(1) >= src_w) ? '0 : col_ff + CntW'(1);
         end else begin
            row_in = row_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store split by row parity; read the pair for the current row
   assign pair_idx = AddrW'(row_ff >> 1);

   always_ff @(posedge clock) begin
      if (is_write && !row_ff[0]) begin
         even_mem[pair_idx] <= in_pixel;
      end
      if (is_write && row_ff[0]) begin
         odd_mem[pair_idx] <= in_pixel;
      end
      even_rd_ff <= even_mem[pair_idx];
      odd_rd_ff  <= odd_mem[pair_idx];
   end

   // Hold the even-row texel of the odd column and the last stored texel
   always_ff @(posedge clock) begin
      if (is_hold) begin
         held_ff <= in_pixel;
      end
      if (is_write) begin
         last_even_ff <= in_pixel;
      end
   end

   // Pick the four texels of the block
   always_comb begin
      if (col_both) begin
         op_a0 = held_ff;
         op_a1 = in_pixel;
         op_c0 = held_ff;
      end else if (row_both) begin
         op_a0 = last_even_ff;
         op_a1 = last_even_ff;
         op_c0 = in_pixel;
      end else begin
         op_a0 = even_rd_ff;
         op_a1 = odd_rd_ff;
         op_c0 = held_ff;
      end
   end

   assign box_q = box4(op_a0, op_a1, op_c0, in_pixel);

   // Register the finished texel for the next level and the output
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (advance) begin
         res_ff.valid <= fire;
         if (fire) begin
            res_ff.pixel <= box_q;
            res_ff.col   <= POS_W'(col_ff >> 1);
            res_ff.row   <= POS_W'(row_ff >> 1);
         end
      end
   end

   assign res = res_ff;

endmodule

FILE: hw/rtl/mbd_out_queue.sv
// Two-entry result queue that parts the level chain from the result port.
// Depends on mbd_pkg for the result word type.
module mbd_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbd_pkg::mbd_rsp_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 out_valid,
   output mbd_pkg::mbd_rsp_type out_data
);
   import mbd_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   mbd_rsp_type     ent_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
      end
   end

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = ent_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/mipmap_box_downsample_pyramid_core.sv
// Mip pyramid core: a chain of level cells, one per mip level, then a result queue.
// Each level's texel is registered in its cell, then written into the result queue that drives rsp_valid.
// Throughput: one texel per cycle while the result queue has room and the texel finishes at most
// one level; past that, input waits while the single word walks the chain one level per cycle.
// Reset (synchronous): counters, chain and queue cleared, size 256 x 256; line stores not cleared.
// Depends on mbd_pkg, mbd_cell and mbd_out_queue.
module mipmap_box_downsample_pyramid_core #(
   parameter int MAX_DIM = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mbd_pkg::PIX_W-1:0]       req_pixel_argb,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mbd_pkg::PIX_W-1:0]       rsp_mip_pixel,
   output logic [mbd_pkg::LEVEL_W-1:0]     rsp_mip_level,
   output logic [mbd_pkg::POS_W-1:0]       rsp_mip_col,
   output logic [mbd_pkg::POS_W-1:0]       rsp_mip_row,
   output logic                            rsp_last_of_run,
   input  logic                            csr_wr_en,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbd_pkg::DIM_W-1:0]       csr_wdata
);
   import mbd_pkg::*;

   localparam int DimCap   = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
   localparam int NumCells = $clog2(DimCap + 1) - 1;
   localparam int DimRst   = (DimCap < DIM_RESET) ? DimCap : DIM_RESET;
   localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DimCap);
   localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(DimRst);

   logic [DIM_W-1:0]    width_ff, height_ff, wdata_clamped;
   logic                cfg_clear;
   logic                advance, busy, queue_full, emit_valid, push, pop;
   logic [NumCells:0]   cell_fire;
   mbd_tok_type         tok [NumCells+1];
   mbd_rsp_type         emit, rsp_word;

   // Clamp written sizes into range
   assign wdata_clamped = (csr_wdata == '0) ? DIM_W'(1) :
                          (csr_wdata > DIM_CAP) ? DIM_CAP : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RST;
         height_ff <= DIM_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEX_WIDTH:  width_ff  <= wdata_clamped;
            CSR_TEX_HEIGHT: height_ff <= wdata_clamped;
            default: ;
         endcase
      end
   end

   // Any size write restarts the texture
   assign cfg_clear = csr_wr_en &&
                      (csr_index == CSR_TEX_WIDTH || csr_index == CSR_TEX_HEIGHT);

   // Freeze the chain while the queue has no room
   assign advance = !queue_full;

   // Hold off input while a word is past the first level
   always_comb begin
      busy = 1'b0;
      for (int j = 2; j <= NumCells; j++) begin
         busy = busy | tok[j].valid;
      end
   end

   assign req_ready = advance && !busy;

   assign tok[0].valid = req_valid && req_ready;
   assign tok[0].pixel = req_pixel_argb;
   assign tok[0].col   = '0;
   assign tok[0].row   = '0;

   // Level cells
   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      mbd_cell #(
         .MAX_DIM (MAX_DIM),
         .LEVEL   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .clear      (cfg_clear),
         .tex_width  (width_ff),
         .tex_height (height_ff),
         .in_valid   (tok[k].valid),
         .in_pixel   (tok[k].pixel),
         .fire       (cell_fire[k]),
         .res        (tok[k+1])
      );
   end

   // Past the last level nothing cascades further
   assign cell_fire[NumCells] = 1'b0;

   // Select the one finished texel in flight; last unless the next level fires
   always_comb begin
      emit_valid = 1'b0;
      emit       = '0;
      for (int j = 1; j <= NumCells; j++) begin
         if (tok[j].valid) begin
            emit_valid = 1'b1;
            emit.pixel = tok[j].pixel;
            emit.level = LEVEL_W'(j);
            emit.col   = tok[j].col;
            emit.row   = tok[j].row;
            emit.last  = !cell_fire[j];
         end
      end
   end

   assign push = advance && emit_valid;
   assign pop  = rsp_valid && rsp_ready;

   mbd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (emit),
      .pop       (pop),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_word)
   );

   assign rsp_mip_pixel   = rsp_word.pixel;
   assign rsp_mip_level   = rsp_word.level;
   assign rsp_mip_col     = rsp_word.col;
   assign rsp_mip_row     = rsp_word.row;
   assign rsp_last_of_run = rsp_word.last;

endmodule

FILE: hw/rtl/mbd_checker.sv
// Port-level checks on the mip pyramid core, bound to the top level.
// Depends on mbd_pkg for widths and on mipmap_box_downsample_pyramid_core.
module mbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mbd_pkg::PIX_W-1:0]       rsp_mip_pixel,
   input logic [mbd_pkg::LEVEL_W-1:0]     rsp_mip_level,
   input logic [mbd_pkg::POS_W-1:0]       rsp_mip_col,
   input logic [mbd_pkg::POS_W-1:0]       rsp_mip_row,
   input logic                            rsp_last_of_run
);
   import mbd_pkg::*;

   logic                chained_ff;
   logic [LEVEL_W-1:0]  prev_level_ff;
   logic [POS_W-1:0]    prev_col_ff, prev_row_ff;
   logic [LEVEL_W-1:0]  exp_level;

   // Remember the previous result word of an unfinished run
   always_ff @(posedge clock) begin
      if (reset) begin
         chained_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         chained_ff    <= !rsp_last_of_run;
         prev_level_ff <= rsp_mip_level;
         prev_col_ff   <= rsp_mip_col;
         prev_row_ff   <= rsp_mip_row;
      end
   end

   assign exp_level = chained_ff ? prev_level_ff + LEVEL_W'(1) : LEVEL_W'(1);

   // A run climbs one level per word, starting at half size
   a_level_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mip_level == exp_level)
      else $error("result level out of sequence");

   // Each deeper level sits at half the coordinates of the one before
   a_coord_halve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chained_ff |->
         rsp_mip_col == (prev_col_ff >> 1) && rsp_mip_row == (prev_row_ff >> 1))
      else $error("cascaded coordinates do not halve");

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_mip_pixel) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

endmodule

bind mipmap_box_downsample_pyramid_core mbd_checker u_mbd_checker (.*);

FILE: bench/mipmap_box_downsample_pyramid_core_tb.sv
// Self-checking bench for mipmap_box_downsample_pyramid_core: streams texels, predicts mip words.
// Depends on mbd_pkg for field widths, register indexes and the result word layout.
`timescale 1ns / 1ps

// Tracks the pyramid state and holds the mip words still due from the core
class mip_pyramid_tracker;
   int unsigned tex_w;
   int unsigned tex_h;
   logic [31:0] even_col [0:8][0:255];
   logic [31:0] odd_hold [0:8];
   int unsigned col_at [0:9];
   int unsigned row_at [0:9];
   mbd_pkg::mbd_rsp_type mip_due [$];
   int unsigned n_fail;
   int unsigned n_checked;
   int unsigned n_reported;
   int unsigned deepest;

   function new();
      tex_w = 256;
      tex_h = 256;
      foreach (even_col[i, j]) even_col[i][j] = '0;
      foreach (odd_hold[i]) odd_hold[i] = '0;
      clear_positions();
      n_fail = 0;
      n_checked = 0;
      n_reported = 0;
      deepest = 0;
   endfunction

   function void clear_positions();
      foreach (col_at[i]) col_at[i] = 0;
      foreach (row_at[i]) row_at[i] = 0;
   endfunction

   // Clamp the code to 1..256; any write to a real register restarts the texture
   function void write_reg(logic [mbd_pkg::CSR_IDX_W-1:0] idx, logic [mbd_pkg::DIM_W-1:0] code);
      int unsigned dim;
      dim = (code == 0) ? 1 : ((code > 256) ? 256 : code);
      if (idx == mbd_pkg::CSR_TEX_WIDTH) tex_w = dim;
      else if (idx == mbd_pkg::CSR_TEX_HEIGHT) tex_h = dim;
      else return;
      clear_positions();
   endfunction

   // Per-channel rounded mean of a 2x2 block
   function logic [31:0] box_mean(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d);
      logic [31:0] res;
      int unsigned s;
      for (int ch = 0; ch < 4; ch++) begin
         s = a[8*ch +: 8] + b[8*ch +: 8] + c[8*ch +: 8] + d[8*ch +: 8] + 2;
         res[8*ch +: 8] = 8'(s >> 2);
      end
      return res;
   endfunction

   // Walk one accepted texel down the levels and queue the burst of mip words it finishes
   function void note_texel(logic [31:0] texel);
      mbd_pkg::mbd_rsp_type burst [$];
      mbd_pkg::mbd_rsp_type w;
      logic [31:0] p, a0, a1, cur0, q;
      int unsigned nlev, k, sw, sh, c, r;
      bit col_one, row_one;
      p = texel;
      nlev = $clog2(tex_w + 1);
      if ($clog2(tex_h + 1) > nlev) nlev = $clog2(tex_h + 1);
      k = 0;
      while (k + 1 < nlev) begin
         sw = tex_w >> k;
         sh = tex_h >> k;
         if (sw == 0) sw = 1;
         if (sh == 0) sh = 1;
         c = col_at[k];
         r = row_at[k];
         col_one = (sw == 1);
         row_one = (sh == 1);
         // advance this level's stream position, row is the fast axis
         if (r + 1 >= sh) begin
            row_at[k] = 0;
            col_at[k] = (c + 1 >= sw) ? 0 : c + 1;
         end else begin
            row_at[k] = r + 1;
         end
         // drop the odd leftover column or row
         if (col_one ? (c != 0) : (c >= (sw / 2) * 2)) break;
         if (row_one ? (r != 0) : (r >= (sh / 2) * 2)) break;
         if (!col_one && (c % 2) == 0) begin
            even_col[k][r] = p;
            break;
         end
         if (!row_one && (r % 2) == 0) begin
            odd_hold[k] = p;
            break;
         end
         cur0 = row_one ? p : odd_hold[k];
         if (col_one) begin
            a0 = cur0;
            a1 = p;
         end else begin
            a0 = even_col[k][row_one ? r : r - 1];
            a1 = even_col[k][r];
         end
         q = box_mean(a0, a1, cur0, p);
         w.pixel = q;
         w.level = 4'(k + 1);
         w.col = 7'(c >> 1);
         w.row = 7'(r >> 1);
         w.last = 1'b0;
         burst.push_back(w);
         if (k + 1 > deepest) deepest = k + 1;
         // cascade the new pixel into the next level
         p = q;
         k++;
      end
      if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) mip_due.push_back(burst[i]);
   endfunction

   // Compare one accepted mip word against the oldest one due
   function void check_mip_word(mbd_pkg::mbd_rsp_type got);
      mbd_pkg::mbd_rsp_type want;
      if (mip_due.size() == 0) begin
         n_fail++;
         if (n_reported++ < 40)
            $display("%0t: unexpected mip word: got pixel %h level %0d col %0d row %0d last %0d",
                     $time, got.pixel, got.level, got.col, got.row, got.last);
         return;
      end
      want = mip_due.pop_front();
      n_checked++;
      if (got.pixel !== want.pixel || got.level !== want.level || got.col !== want.col ||
          got.row !== want.row || got.last !== want.last) begin
         n_fail++;
         if (n_reported++ < 40) begin
            $display("%0t: mip word mismatch: expected pixel %h level %0d col %0d row %0d last %0d",
                     $time, want.pixel, want.level, want.col, want.row, want.last);
            $display("%0t:                         got pixel %h level %0d col %0d row %0d last %0d",
                     $time, got.pixel, got.level, got.col, got.row, got.last);
         end
      end
   endfunction
endclass

module mipmap_box_downsample_pyramid_core_tb;
   import mbd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 32;
   localparam int RANDOM_ITEMS = 75;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_argb = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_W-1:0]     rsp_mip_pixel;
   logic [LEVEL_W-1:0]   rsp_mip_level;
   logic [POS_W-1:0]     rsp_mip_col;
   logic [POS_W-1:0]     rsp_mip_row;
   logic                 rsp_last_of_run;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   mip_pyramid_tracker pyramid;
   int unsigned cycle_count = 0;
   int unsigned n_texels = 0;
   int unsigned n_sizes = 0;
   int unsigned hold_rsp = 0;
   bit calm = 1'b0;

   mipmap_box_downsample_pyramid_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_argb(req_pixel_argb),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mip_pixel(rsp_mip_pixel),
      .rsp_mip_level(rsp_mip_level),
      .rsp_mip_col(rsp_mip_col),
      .rsp_mip_row(rsp_mip_row),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Mostly no gap, some short ones, a few long
   function automatic int unsigned pick_gap();
      int unsigned sel;
      if (calm) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   // Random texel, with some words biased toward the channel extremes
   function automatic logic [PIX_W-1:0] rand_texel();
      logic [PIX_W-1:0] px;
      int unsigned sel, pick;
      sel = $urandom_range(0, 9);
      if (sel < 8) return $urandom;
      if (sel == 8) return $urandom_range(0, 1) ? '1 : '0;
      for (int ch = 0; ch < 4; ch++) begin
         pick = $urandom_range(0, 5);
         px[8*ch +: 8] = (pick < 3) ? 8'(pick) : 8'(8'hFF - (pick - 3));
      end
      return px;
   endfunction

   // Stall the result side at random
   always @(posedge clock) begin
      if (hold_rsp != 0) begin
         hold_rsp--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 4) == 0) hold_rsp = pick_gap();
      end
   end

   // Check every accepted mip word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pyramid.check_mip_word({rsp_mip_pixel, rsp_mip_level, rsp_mip_col, rsp_mip_row,
                                 rsp_last_of_run});
   end

   // Offer one texel word and hold it until accepted
   task automatic send_texel(input logic [PIX_W-1:0] texel);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_argb <= texel;
      do @(posedge clock); while (!req_ready);
      pyramid.note_texel(texel);
      n_texels++;
   endtask

   // Drop valid, wait for every due mip word, then let the cell chain settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pyramid.mip_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one register; the caller lowers the write enable
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] code);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= code;
      @(posedge clock);
      pyramid.write_reg(idx, code);
   endtask

   task automatic set_size(input logic [DIM_W-1:0] wcode, input logic [DIM_W-1:0] hcode);
      drain_pipeline();
      if ($urandom_range(0, 1) != 0) begin
         write_csr(CSR_TEX_WIDTH, wcode);
         write_csr(CSR_TEX_HEIGHT, hcode);
      end else begin
         write_csr(CSR_TEX_HEIGHT, hcode);
         write_csr(CSR_TEX_WIDTH, wcode);
      end
      csr_wr_en <= 1'b0;
      n_sizes++;
   endtask

   // Timeout guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d mip words still due", cycle_count,
               pyramid.mip_due.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned random_start, sel, area, n_items;
      logic [DIM_W-1:0] wc, hc;
      pyramid = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset size is 256 x 256: the first column finishes nothing
      repeat (4) send_texel(rand_texel());

      // 2x2: full scale, rounding up and down, three textures back to back
      set_size(9'd2, 9'd2);
      repeat (4) send_texel(32'hFFFF_FFFF);
      send_texel(32'h0101_0101);
      send_texel(32'h0101_0101);
      send_texel(32'h0000_0000);
      send_texel(32'h0000_0000);
      send_texel(32'h0000_0001);
      send_texel(32'h0000_0000);
      send_texel(32'h0000_0000);
      send_texel(32'h0000_0000);

      // 3x3: odd leftover row and column; a spare index write must not restart the texture
      set_size(9'd3, 9'd3);
      repeat (4) send_texel(rand_texel());
      drain_pipeline();
      write_csr(CSR_SPARE, 9'd5);
      csr_wr_en <= 1'b0;
      repeat (5) send_texel(rand_texel());

      // Out-of-range codes: 300 x 0 clamps to 256 x 1; the first 32 columns reach level 5
      set_size(9'd300, 9'd0);
      repeat (32) send_texel(rand_texel());

      // 0 x 511 clamps to 1 x 256, first half without idling
      set_size(9'd0, 9'd511);
      calm = 1'b1;
      repeat (16) send_texel(rand_texel());
      calm = 1'b0;
      repeat (16) send_texel(rand_texel());

      // Exact 256 wide, cut short by the next write
      set_size(9'd256, 9'd2);
      repeat (8) send_texel(rand_texel());

      // Random sizes, mostly small, full textures with some cut short
      random_start = n_texels;
      while (n_texels < random_start + RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel < 13) begin
            wc = DIM_W'($urandom_range(1, 8));
            hc = DIM_W'($urandom_range(1, 8));
         end else if (sel < 18) begin
            wc = DIM_W'($urandom_range(1, 16));
            hc = DIM_W'($urandom_range(1, 16));
         end else if (sel == 18) begin
            wc = DIM_W'($urandom_range(0, 511));
            hc = DIM_W'($urandom_range(1, 4));
         end else begin
            wc = DIM_W'($urandom_range(1, 4));
            hc = DIM_W'($urandom_range(0, 511));
         end
         set_size(wc, hc);
         calm = ($urandom_range(0, 3) == 0);
         area = pyramid.tex_w * pyramid.tex_h;
         if (area <= 40) n_items = area * $urandom_range(1, 2) + $urandom_range(0, area / 2);
         else n_items = $urandom_range(10, 80);
         if (n_items > random_start + RANDOM_ITEMS - n_texels)
            n_items = random_start + RANDOM_ITEMS - n_texels;
         repeat (n_items) send_texel(rand_texel());
      end
      calm = 1'b0;

      drain_pipeline();
      $display("sent %0d texels over %0d texture sizes, checked %0d mip words, levels 1 to %0d",
               n_texels, n_sizes, pyramid.n_checked, pyramid.deepest);
      if (pyramid.n_fail == 0 && pyramid.mip_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures, %0d mip words never arrived", pyramid.n_fail,
                  pyramid.mip_due.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: mipmap_box_downsample_pyramid_core.f
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_cell.sv
hw/rtl/mbd_out_queue.sv
hw/rtl/mipmap_box_downsample_pyramid_core.sv
hw/rtl/mbd_checker.sv
bench/mipmap_box_downsample_pyramid_core_tb.sv
